### rtl/core/tksort_pkg.sv
// ----------------------------------------------------------------------------
// tksort_pkg
// Shared types and constants for the two-key record sorter.
// ----------------------------------------------------------------------------
package tksort_pkg;

  localparam int unsigned MaxRecords = 32;
  localparam int unsigned IdxW       = $clog2(MaxRecords);
  localparam int unsigned CntW       = $clog2(MaxRecords + 1);

  localparam int unsigned TagW  = 16;
  localparam int unsigned RollW = 16;
  localparam int unsigned MarkW = 10;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [RollW-1:0] roll;
    logic [MarkW-1:0] mark;
  } rec_t;

endpackage

### rtl/core/tksort_cmp.sv
// ----------------------------------------------------------------------------
// tksort_cmp
// Shared record comparator: flags when record a must sit strictly ahead of
// record b (higher mark first, then lower roll first).
// ----------------------------------------------------------------------------
module tksort_cmp import tksort_pkg::*; (
  input  rec_t a_i,
  input  rec_t b_i,
  output logic before_o
);

  logic mark_gt;
  logic mark_eq;
  logic roll_lt;

  assign mark_gt  = a_i.mark > b_i.mark;
  assign mark_eq  = a_i.mark == b_i.mark;
  assign roll_lt  = a_i.roll < b_i.roll;
  // equal records do not go ahead, so load order is kept
  assign before_o = mark_gt | (mark_eq & roll_lt);

endmodule

### rtl/core/two_key_record_sorter_top.sv
// ----------------------------------------------------------------------------
// two_key_record_sorter_top
// Batch record sorter with an insertion store and a single shared comparator.
//
// The input channel (in_valid_i/in_ready_o) takes one record word at a time:
// name tag, roll number, mark and a batch_last bit. Each word is inserted
// into a sorted 32-entry store by walking from the tail toward the head,
// one comparison and one entry move per cycle through a single-port-read,
// single-port-write memory. An accepted word is compared with each stored
// record it passes and with the one it stops behind, if any (none when
// the store is empty), then written into its slot. A word that arrives
// with the store full is dropped at acceptance and marks the batch as
// overflowed.
// When the batch_last word has been handled, the whole batch leaves on the
// output channel (out_valid_o/out_ready_i), best mark first, lower roll
// first on equal marks. Each output word goes through a memory read, an
// output register load and the handshake, held while the receiver stalls;
// out_last_o marks the final word and overflow_seen_o is set on every word
// of a batch that dropped records. in_ready_o stays low during insertion
// and emission. The receiver may stall freely: the output register holds.
// Reset empties the store (count and overflow cleared); no clearing pass.
// ----------------------------------------------------------------------------
module two_key_record_sorter_top import tksort_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [TagW-1:0]  name_tag_i,
  input  logic [RollW-1:0] roll_number_i,
  input  logic [MarkW-1:0] mark_value_i,
  input  logic             batch_last_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [TagW-1:0]  out_name_tag_o,
  output logic [RollW-1:0] out_roll_o,
  output logic [MarkW-1:0] out_mark_o,
  output logic             out_last_o,
  output logic             overflow_seen_o
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_CMP       = 3'd1;
  localparam logic [2:0] S_PUT       = 3'd2;
  localparam logic [2:0] S_EMIT_RD   = 3'd3;
  localparam logic [2:0] S_EMIT_LD   = 3'd4;
  localparam logic [2:0] S_EMIT_WAIT = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            last_q, last_d;
  logic [IdxW-1:0] idx_q, idx_d;
  rec_t            new_q, new_d;

  rec_t            out_rec_q, out_rec_d;
  logic            out_valid_q, out_valid_d;
  logic            out_last_q, out_last_d;
  logic            out_ovf_q, out_ovf_d;

  rec_t            mem [MaxRecords];
  rec_t            rdata_q;
  logic [IdxW-1:0] rd_addr;
  logic            we;
  logic [IdxW-1:0] wr_addr;
  rec_t            wr_data;

  logic            in_acc;
  logic            out_acc;
  logic            ahead;
  rec_t            in_rec;

  assign in_rec.tag  = name_tag_i;
  assign in_rec.roll = roll_number_i;
  assign in_rec.mark = mark_value_i;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_acc    = out_valid_q & out_ready_i;

  tksort_cmp u_cmp (
    .a_i      (new_q),
    .b_i      (rdata_q),
    .before_o (ahead)
  );

  // record store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    idx_d       = idx_q;
    new_d       = new_q;
    out_rec_d   = out_rec_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    we          = 1'b0;
    wr_addr     = idx_q;
    wr_data     = new_q;
    rd_addr     = idx_q;

    unique case (state_q)
      S_IDLE: begin
        rd_addr = IdxW'(cnt_q - 1'b1);
        if (in_acc) begin
          new_d  = in_rec;
          last_d = batch_last_i;
          if (cnt_q == CntW'(MaxRecords)) begin
            // drop the word, keep the batch
            ovf_d = 1'b1;
            idx_d = '0;
            if (batch_last_i) begin
              state_d = S_EMIT_RD;
            end
          end else if (cnt_q == '0) begin
            idx_d   = '0;
            state_d = S_PUT;
          end else begin
            idx_d   = IdxW'(cnt_q - 1'b1);
            state_d = S_CMP;
          end
        end
      end

      S_CMP: begin
        rd_addr = idx_q - 1'b1;
        if (ahead) begin
          // shift the stored record one slot toward the tail
          we      = 1'b1;
          wr_addr = idx_q + 1'b1;
          wr_data = rdata_q;
          if (idx_q == '0) begin
            state_d = S_PUT;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_PUT;
        end
      end

      S_PUT: begin
        we      = 1'b1;
        wr_addr = idx_q;
        wr_data = new_q;
        cnt_d   = cnt_q + 1'b1;
        idx_d   = '0;
        state_d = last_q ? S_EMIT_RD : S_IDLE;
      end

      S_EMIT_RD: begin
        rd_addr = idx_q;
        state_d = (cnt_q == '0) ? S_IDLE : S_EMIT_LD;
      end

      S_EMIT_LD: begin
        out_rec_d   = rdata_q;
        out_valid_d = 1'b1;
        out_last_d  = (CntW'(idx_q) + 1'b1) == cnt_q;
        out_ovf_d   = ovf_q;
        state_d     = S_EMIT_WAIT;
      end

      S_EMIT_WAIT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      last_q      <= last_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q     <= new_d;
    out_rec_q <= out_rec_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_name_tag_o  = out_rec_q.tag;
  assign out_roll_o      = out_rec_q.roll;
  assign out_mark_o      = out_rec_q.mark;
  assign out_last_o      = out_last_q;
  assign overflow_seen_o = out_ovf_q;

  // input and output sides never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("output word pending while input is open");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxRecords))
    else $error("record count beyond store capacity");

  a_last_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_last_o) |=> (in_ready_o && cnt_q == '0 && !ovf_q))
    else $error("batch not cleared after final word");

  a_out_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == S_EMIT_WAIT))
    else $error("output valid outside emission");

endmodule

### bench/tb_two_key_record_sorter_top.sv
// ----------------------------------------------------------------------------
// tb_two_key_record_sorter_top
// Self-checking bench for the two-key record sorter. Record batches are
// pushed over the input valid/ready channel. A scoreboard keeps its own
// sorted copy of each batch and checks every emitted word in order.
// Coverage: small directed batches (field extremes, ties on mark and roll,
// fully equal records), then random batches that include a full store and
// overflow cases. Both channels idle at random, and the receiver holds off
// once for a long stretch.
// ----------------------------------------------------------------------------
module tb_two_key_record_sorter_top import tksort_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    rec_t rec;
    logic last;
    logic ovf;
  } ranked_word_t;

  class rank_scoreboard;
    rec_t           held[MaxRecords];
    int unsigned    held_count;
    logic           dropped;
    ranked_word_t   ranked_q[$];
    int unsigned    errors;
    int unsigned    words_checked;
    int unsigned    batches;
    int unsigned    overflow_batches;

    function new();
      held_count = 0;
      dropped = 1'b0;
      errors = 0;
      words_checked = 0;
      batches = 0;
      overflow_batches = 0;
    endfunction

    // Insert an accepted record in rank order; on the closing record queue
    // the whole batch as expected output.
    function void note_record(rec_t r, logic last);
      int unsigned pos;
      int unsigned i;
      ranked_word_t w;
      if (held_count < MaxRecords) begin
        pos = 0;
        // advance past every entry that ranks ahead of or ties with r
        while (pos < held_count &&
               !(r.mark > held[pos].mark ||
                 (r.mark == held[pos].mark && r.roll < held[pos].roll)))
          pos++;
        for (i = held_count; i > pos; i--)
          held[i] = held[i-1];
        held[pos] = r;
        held_count++;
      end else begin
        dropped = 1'b1;
      end
      if (last) begin
        for (i = 0; i < held_count; i++) begin
          w.rec  = held[i];
          w.last = (i + 1 == held_count);
          w.ovf  = dropped;
          ranked_q.push_back(w);
        end
        batches++;
        if (dropped) overflow_batches++;
        held_count = 0;
        dropped = 1'b0;
      end
    endfunction

    function void report(string field, int unsigned exp_v, int unsigned act_v);
      errors++;
      $display("%0t: %s mismatch: expected %0h actual %0h", $time, field, exp_v, act_v);
    endfunction

    function void check_word(rec_t got, logic last, logic ovf);
      ranked_word_t w;
      words_checked++;
      if (ranked_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none actual tag %0h roll %0h mark %0h",
                 $time, got.tag, got.roll, got.mark);
        return;
      end
      w = ranked_q.pop_front();
      if (got.tag  !== w.rec.tag)  report("name tag", w.rec.tag, got.tag);
      if (got.roll !== w.rec.roll) report("roll", w.rec.roll, got.roll);
      if (got.mark !== w.rec.mark) report("mark", w.rec.mark, got.mark);
      if (last !== w.last)         report("last", w.last, last);
      if (ovf !== w.ovf)           report("overflow", w.ovf, ovf);
    endfunction

    function int unsigned pending();
      return ranked_q.size();
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [TagW-1:0]  name_tag_i;
  logic [RollW-1:0] roll_number_i;
  logic [MarkW-1:0] mark_value_i;
  logic             batch_last_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [TagW-1:0]  out_name_tag_o;
  logic [RollW-1:0] out_roll_o;
  logic [MarkW-1:0] out_mark_o;
  logic             out_last_o;
  logic             overflow_seen_o;

  rank_scoreboard sb = new();
  bit             calm = 1'b0;
  bit             pressure_done = 1'b0;

  two_key_record_sorter_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .name_tag_i      (name_tag_i),
    .roll_number_i   (roll_number_i),
    .mark_value_i    (mark_value_i),
    .batch_last_i    (batch_last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_name_tag_o  (out_name_tag_o),
    .out_roll_o      (out_roll_o),
    .out_mark_o      (out_mark_o),
    .out_last_o      (out_last_o),
    .overflow_seen_o (overflow_seen_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(logic [TagW-1:0] tag, logic [RollW-1:0] roll,
                           logic [MarkW-1:0] mark, logic last);
    int unsigned gaps;
    rec_t r;
    gaps = (!calm && $urandom_range(99) < 11) ? $urandom_range(1, 4) : 0;
    if (gaps != 0) begin
      in_valid_i <= 1'b0;
      repeat (gaps) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    name_tag_i    <= tag;
    roll_number_i <= roll;
    mark_value_i  <= mark;
    batch_last_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    r.tag  = tag;
    r.roll = roll;
    r.mark = mark;
    sb.note_record(r, last);
    @(negedge clk_i);
  endtask

  // Receiver: random stalls, one long hold-off once output is under way.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!pressure_done && sb.words_checked >= 40) begin
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
        pressure_done = 1'b1;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 11);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_word(rec_t'{tag: out_name_tag_o, roll: out_roll_o, mark: out_mark_o},
                    out_last_o, overflow_seen_o);
  end

  initial begin
    int unsigned batch_idx;
    int unsigned batch_len;
    int unsigned sent;
    int unsigned k;
    logic [MarkW-1:0] mark;
    logic [RollW-1:0] roll;

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    name_tag_i    = '0;
    roll_number_i = '0;
    mark_value_i  = '0;
    batch_last_i  = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // single-record batches at the field extremes
    send_word(16'h0000, 16'h0000, 10'h000, 1'b1);
    send_word(16'hFFFF, 16'hFFFF, 10'h3FF, 1'b1);
    // mixed marks with ties on the top and bottom mark
    send_word(16'h1111, 16'h0005, 10'd0,    1'b0);
    send_word(16'h2222, 16'h0003, 10'd1023, 1'b0);
    send_word(16'h3333, 16'h0009, 10'd500,  1'b0);
    send_word(16'h4444, 16'h0001, 10'd1023, 1'b0);
    send_word(16'h5555, 16'h0002, 10'd0,    1'b1);
    // fully equal records keep load order; a lower roll jumps ahead
    send_word(16'hA001, 16'd9, 10'd7, 1'b0);
    send_word(16'hA002, 16'd9, 10'd7, 1'b0);
    send_word(16'hA003, 16'd9, 10'd7, 1'b0);
    send_word(16'hA004, 16'd9, 10'd7, 1'b0);
    send_word(16'hA005, 16'd8, 10'd7, 1'b1);
    // equal marks, rolls at both ends
    send_word(16'hBEEF, 16'hFFFF, 10'd300, 1'b0);
    send_word(16'hCAFE, 16'h0000, 10'd300, 1'b0);
    send_word(16'hD00D, 16'd100,  10'd300, 1'b1);

    // random batches; a few are forced to fill or overflow the store
    sent = 0;
    batch_idx = 0;
    while (sent < 350) begin
      case (batch_idx)
        2:       batch_len = MaxRecords;
        5:       batch_len = MaxRecords + 1;   // closing record itself dropped
        9:       batch_len = MaxRecords + 8;
        default: batch_len = ($urandom_range(19) == 0) ? $urandom_range(30, 38)
                                                       : $urandom_range(1, 8);
      endcase
      calm = (batch_idx >= 14 && batch_idx < 24);
      for (k = 0; k < batch_len; k++) begin
        mark = ($urandom_range(3) == 0) ? MarkW'($urandom_range(2))
                                        : MarkW'($urandom_range(1023));
        roll = ($urandom_range(3) == 0) ? RollW'($urandom_range(1))
                                        : RollW'($urandom_range(65535));
        send_word(TagW'($urandom_range(65535)), roll, mark, k + 1 == batch_len);
      end
      sent += batch_len;
      batch_idx++;
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Covered %0d batches (%0d with dropped records), %0d sorted words checked",
             sb.batches, sb.overflow_batches, sb.words_checked);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d sorted words still outstanding", sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
